// ===== hdl/velocity_rollout_trajectory_unit_assert.svh =====
// assertion macros shared by the rollout design
`ifndef VELOCITY_ROLLOUT_TRAJECTORY_UNIT_ASSERT_SVH
`define VELOCITY_ROLLOUT_TRAJECTORY_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VRT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rollout check failed");

// next-cycle implication, checked out of reset
`define VRT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rollout check failed");

`endif

// ===== hdl/vrt_pkg.sv =====
package vrt_pkg;

    localparam int MAX_STEPS = 64;
    localparam int IDX_W     = $clog2(MAX_STEPS);
    localparam int CORDIC_N  = 14;

    // register indexes
    localparam logic [2:0] REG_ACCEL_X    = 3'd0;
    localparam logic [2:0] REG_DECEL_X    = 3'd1;
    localparam logic [2:0] REG_ACCEL_Y    = 3'd2;
    localparam logic [2:0] REG_DECEL_Y    = 3'd3;
    localparam logic [2:0] REG_ACCEL_TURN = 3'd4;
    localparam logic [2:0] REG_DECEL_TURN = 3'd5;
    localparam logic [2:0] REG_TIME_STEP  = 3'd6;
    localparam logic [2:0] REG_STEPS      = 3'd7;

    localparam logic signed [17:0] CORDIC_GAIN = 18'sd9949;

    // cordic arctangent table, binary angle units
    function automatic logic signed [16:0] atan_lut(input logic [3:0] i);
        logic signed [16:0] r;
        case (i)
            4'd0:    r = 17'sd8192;
            4'd1:    r = 17'sd4836;
            4'd2:    r = 17'sd2555;
            4'd3:    r = 17'sd1297;
            4'd4:    r = 17'sd651;
            4'd5:    r = 17'sd326;
            4'd6:    r = 17'sd163;
            4'd7:    r = 17'sd81;
            4'd8:    r = 17'sd41;
            4'd9:    r = 17'sd20;
            4'd10:   r = 17'sd10;
            4'd11:   r = 17'sd5;
            4'd12:   r = 17'sd3;
            4'd13:   r = 17'sd1;
            default: r = 17'sd0;
        endcase
        return r;
    endfunction

    // move velocity by d toward target, clamp at target, saturate to 24 bits
    function automatic logic signed [23:0] project(input logic signed [23:0] v,
                                                   input logic signed [23:0] tgt,
                                                   input logic signed [23:0] d);
        logic signed [24:0] n;
        logic signed [24:0] t;
        n = 25'(v) + 25'(d);
        t = 25'(tgt);
        if (v < tgt) begin
            if (n > t) n = t;
        end else begin
            if (n < t) n = t;
        end
        if (n > 25'sd8388607) n = 25'sd8388607;
        if (n < -25'sd8388608) n = -25'sd8388608;
        return n[23:0];
    endfunction

    // saturate a position sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hdl/velocity_rollout_trajectory_unit.sv =====
// channel  | direction | handshake          | words
// s_       | in        | s_valid / s_ready  | one start pose, current and target velocities
// m_       | out       | m_valid / m_ready  | one pose per word, up to 64 per item
// cfg_     | in        | cfg_wen            | one register write
// each later pose runs the velocity, cordic, fold, rotate and heading states in turn
// all products go through one shared 25x18 multiplier; the cordic loop uses shifts and adds
// aresetn is synchronous; control clears, the configuration registers take their reset values
// the block takes no new item until the last pose of a rollout is taken
module velocity_rollout_trajectory_unit
    import vrt_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wen,
    input  logic [2:0]              cfg_index,
    input  logic [23:0]             cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [31:0]      s_start_x,
    input  logic signed [31:0]      s_start_y,
    input  logic [15:0]             s_start_heading,
    input  logic signed [23:0]      s_cur_vx,
    input  logic signed [23:0]      s_cur_vy,
    input  logic signed [23:0]      s_cur_vturn,
    input  logic signed [23:0]      s_tgt_vx,
    input  logic signed [23:0]      s_tgt_vy,
    input  logic signed [23:0]      s_tgt_vturn,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [31:0]      m_pose_x,
    output logic signed [31:0]      m_pose_y,
    output logic [15:0]             m_pose_heading,
    output logic [IDX_W-1:0]        m_step_index,
    output logic                    m_last_pose
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_EMIT,
        ST_VX_M, ST_VX_U, ST_VY_M, ST_VY_U, ST_VT_M, ST_VT_U,
        ST_ROT, ST_FOLD,
        ST_PX_M1, ST_PX_M2, ST_PX_S, ST_PX_H, ST_PX_L, ST_PX_U,
        ST_PY_M1, ST_PY_M2, ST_PY_S, ST_PY_H, ST_PY_L, ST_PY_U,
        ST_HD_M, ST_HD_U
    } state_t;

    state_t state_reg;

    logic signed [23:0] accel_x_reg, decel_x_reg, accel_y_reg, decel_y_reg;
    logic signed [23:0] accel_turn_reg, decel_turn_reg;
    logic [15:0]        dt_reg;
    logic [6:0]         steps_reg;

    logic signed [31:0] px_reg, py_reg;
    logic [23:0]        hd_reg;
    logic signed [23:0] vx_reg, vy_reg, vt_reg, tx_reg, ty_reg, tt_reg;
    logic [IDX_W-1:0]   k_reg, last_idx_reg;

    logic signed [17:0] rot_x_reg, rot_y_reg, cos_reg, sin_reg;
    logic signed [16:0] rot_z_reg;
    logic [3:0]         iter_reg;
    logic [1:0]         quad_reg;

    logic signed [42:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [43:0] a_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_x_reg    <= 24'sd163840;
            decel_x_reg    <= -24'sd163840;
            accel_y_reg    <= 24'sd163840;
            decel_y_reg    <= -24'sd163840;
            accel_turn_reg <= 24'sd4194304;
            decel_turn_reg <= -24'sd4194304;
            dt_reg         <= 16'd6554;
            steps_reg      <= 7'd15;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_ACCEL_X:    accel_x_reg    <= cfg_wdata;
                REG_DECEL_X:    decel_x_reg    <= cfg_wdata;
                REG_ACCEL_Y:    accel_y_reg    <= cfg_wdata;
                REG_DECEL_Y:    decel_y_reg    <= cfg_wdata;
                REG_ACCEL_TURN: accel_turn_reg <= cfg_wdata;
                REG_DECEL_TURN: decel_turn_reg <= cfg_wdata;
                REG_TIME_STEP:  dt_reg         <= cfg_wdata[15:0];
                REG_STEPS:      steps_reg      <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [17:0] dt_s;
    logic signed [42:0] mul_p;

    assign dt_s = signed'({2'b00, dt_reg});

    always_comb begin
        mul_a = '0;
        mul_b = dt_s;
        case (state_reg)
            ST_VX_M:  mul_a = 25'((vx_reg < tx_reg) ? accel_x_reg : decel_x_reg);
            ST_VY_M:  mul_a = 25'((vy_reg < ty_reg) ? accel_y_reg : decel_y_reg);
            ST_VT_M:  mul_a = 25'((vt_reg < tt_reg) ? accel_turn_reg : decel_turn_reg);
            ST_HD_M:  mul_a = 25'(vt_reg);
            ST_PX_M1: begin mul_a = 25'(vx_reg); mul_b = cos_reg; end
            ST_PX_M2: begin mul_a = 25'(vy_reg); mul_b = sin_reg; end
            ST_PY_M1: begin mul_a = 25'(vx_reg); mul_b = sin_reg; end
            ST_PY_M2: begin mul_a = 25'(vy_reg); mul_b = cos_reg; end
            ST_PX_H, ST_PY_H: mul_a = 25'(signed'(a_reg[43:20]));
            ST_PX_L, ST_PY_L: mul_a = signed'({5'b00000, a_reg[19:0]});
            default: mul_a = '0;
        endcase
    end

    assign mul_p = 43'(mul_a * mul_b);

    // cordic step and quadrant fold
    logic [15:0]        h16;
    logic [15:0]        hq;
    logic [15:0]        zq;
    logic signed [17:0] ysh, xsh;
    logic signed [63:0] pos_sum;
    logic signed [34:0] pos_next;

    assign h16 = hd_reg[23:8];
    assign hq  = h16 + 16'd8192;
    assign zq  = h16 - {hq[15:14], 14'd0};
    assign ysh = rot_y_reg >>> iter_reg;
    assign xsh = rot_x_reg >>> iter_reg;
    assign pos_sum = acc_reg + 64'(prod_reg);
    assign pos_next = 35'(pos_sum >>> 30);

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_EMIT);
    assign m_pose_x       = px_reg;
    assign m_pose_y       = py_reg;
    assign m_pose_heading = hd_reg[23:8];
    assign m_step_index   = k_reg;
    assign m_last_pose    = (k_reg == last_idx_reg);

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            prod_reg <= mul_p;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        px_reg <= s_start_x;
                        py_reg <= s_start_y;
                        hd_reg <= {s_start_heading, 8'd0};
                        vx_reg <= s_cur_vx;
                        vy_reg <= s_cur_vy;
                        vt_reg <= s_cur_vturn;
                        tx_reg <= s_tgt_vx;
                        ty_reg <= s_tgt_vy;
                        tt_reg <= s_tgt_vturn;
                        k_reg  <= '0;
                        if (steps_reg == 7'd0)
                            last_idx_reg <= '0;
                        else if (steps_reg > 7'(MAX_STEPS))
                            last_idx_reg <= IDX_W'(MAX_STEPS - 1);
                        else
                            last_idx_reg <= IDX_W'(steps_reg - 7'd1);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        if (k_reg == last_idx_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_VX_M;
                        end
                    end
                end
                ST_VX_M: state_reg <= ST_VX_U;
                ST_VX_U: begin
                    vx_reg    <= project(vx_reg, tx_reg, prod_reg[39:16]);
                    state_reg <= ST_VY_M;
                end
                ST_VY_M: state_reg <= ST_VY_U;
                ST_VY_U: begin
                    vy_reg    <= project(vy_reg, ty_reg, prod_reg[39:16]);
                    state_reg <= ST_VT_M;
                end
                ST_VT_M: state_reg <= ST_VT_U;
                ST_VT_U: begin
                    vt_reg    <= project(vt_reg, tt_reg, prod_reg[39:16]);
                    rot_x_reg <= CORDIC_GAIN;
                    rot_y_reg <= '0;
                    rot_z_reg <= 17'(signed'(zq));
                    quad_reg  <= hq[15:14];
                    iter_reg  <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT: begin
                    if (rot_z_reg >= 0) begin
                        rot_x_reg <= rot_x_reg - ysh;
                        rot_y_reg <= rot_y_reg + xsh;
                        rot_z_reg <= rot_z_reg - atan_lut(iter_reg);
                    end else begin
                        rot_x_reg <= rot_x_reg + ysh;
                        rot_y_reg <= rot_y_reg - xsh;
                        rot_z_reg <= rot_z_reg + atan_lut(iter_reg);
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == 4'(CORDIC_N - 1))
                        state_reg <= ST_FOLD;
                end
                ST_FOLD: begin
                    case (quad_reg)
                        2'd0:    begin cos_reg <= rot_x_reg;  sin_reg <= rot_y_reg;  end
                        2'd1:    begin cos_reg <= -rot_y_reg; sin_reg <= rot_x_reg;  end
                        2'd2:    begin cos_reg <= -rot_x_reg; sin_reg <= -rot_y_reg; end
                        default: begin cos_reg <= rot_y_reg;  sin_reg <= -rot_x_reg; end
                    endcase
                    state_reg <= ST_PX_M1;
                end
                ST_PX_M1: state_reg <= ST_PX_M2;
                ST_PX_M2: begin
                    acc_reg   <= 64'(prod_reg);
                    state_reg <= ST_PX_S;
                end
                ST_PX_S: begin
                    a_reg     <= 44'(acc_reg) - 44'(prod_reg);
                    state_reg <= ST_PX_H;
                end
                ST_PX_H: state_reg <= ST_PX_L;
                ST_PX_L: begin
                    acc_reg   <= 64'(prod_reg) <<< 20;
                    state_reg <= ST_PX_U;
                end
                ST_PX_U: begin
                    px_reg    <= sat32(35'(px_reg) + pos_next);
                    state_reg <= ST_PY_M1;
                end
                ST_PY_M1: state_reg <= ST_PY_M2;
                ST_PY_M2: begin
                    acc_reg   <= 64'(prod_reg);
                    state_reg <= ST_PY_S;
                end
                ST_PY_S: begin
                    a_reg     <= 44'(acc_reg) + 44'(prod_reg);
                    state_reg <= ST_PY_H;
                end
                ST_PY_H: state_reg <= ST_PY_L;
                ST_PY_L: begin
                    acc_reg   <= 64'(prod_reg) <<< 20;
                    state_reg <= ST_PY_U;
                end
                ST_PY_U: begin
                    py_reg    <= sat32(35'(py_reg) + pos_next);
                    state_reg <= ST_HD_M;
                end
                ST_HD_M: state_reg <= ST_HD_U;
                ST_HD_U: begin
                    hd_reg    <= hd_reg + prod_reg[39:16];
                    state_reg <= ST_EMIT;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `include "velocity_rollout_trajectory_unit_assert.svh"

    `VRT_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    `VRT_ASSERT_NOW(a_last_index, aclk, aresetn, m_valid && m_last_pose, m_step_index == last_idx_reg)
    `VRT_ASSERT_NEXT(a_done_idle, aclk, aresetn, m_valid && m_ready && m_last_pose, s_ready)
    `VRT_ASSERT_NEXT(a_step_gap, aclk, aresetn, m_valid && m_ready && !m_last_pose, !m_valid && !s_ready)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import vrt_pkg::*;

    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic [15:0]        shd;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] vt;
        logic signed [23:0] tx;
        logic signed [23:0] ty;
        logic signed [23:0] tt;
    } start_word_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        hd;
        logic [IDX_W-1:0]   idx;
        logic               last;
    } pose_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wen = 1'b0;
    logic [2:0]          cfg_index = REG_ACCEL_X;
    logic [23:0]         cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic signed [31:0]  s_start_x = '0;
    logic signed [31:0]  s_start_y = '0;
    logic [15:0]         s_start_heading = '0;
    logic signed [23:0]  s_cur_vx = '0;
    logic signed [23:0]  s_cur_vy = '0;
    logic signed [23:0]  s_cur_vturn = '0;
    logic signed [23:0]  s_tgt_vx = '0;
    logic signed [23:0]  s_tgt_vy = '0;
    logic signed [23:0]  s_tgt_vturn = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [31:0]  m_pose_x;
    logic signed [31:0]  m_pose_y;
    logic [15:0]         m_pose_heading;
    logic [IDX_W-1:0]    m_step_index;
    logic                m_last_pose;

    // shadow of the rate registers in the order of the register indexes
    longint      rate_reg [6];
    longint      dt_reg;
    int unsigned steps_reg;

    pose_t       pose_q[$];
    int          err_cnt = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    velocity_rollout_trajectory_unit i_dut (.*);

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // velocity step toward target, clamped at target, saturated to 24 bits
    function automatic longint project_vel(longint v, longint acc, longint dec, longint tgt);
        longint n;
        if (v < tgt) begin
            n = v + ((acc * dt_reg) >>> 16);
            if (n > tgt) n = tgt;
        end else begin
            n = v + ((dec * dt_reg) >>> 16);
            if (n < tgt) n = tgt;
        end
        if (n > 8388607) n = 8388607;
        if (n < -8388608) n = -8388608;
        return n;
    endfunction

    // cordic cosine and sine in q1.14 with quadrant folding
    function automatic void heading_cos_sin(int h, output longint c, output longint s);
        int q;
        int z;
        int x;
        int y;
        int nx;
        int atan_v [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        q = ((h + 8192) >> 14) & 3;
        z = (h - q * 16384) & 16'hFFFF;
        if (z >= 32768) z -= 65536;
        x = 9949;
        y = 0;
        for (int i = 0; i < 14; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_v[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_v[i];
            end
            x = nx;
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint sat_pos(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // expected poses of one rollout
    function automatic void predict_rollout(start_word_t w);
        longint px, py, vx, vy, vt, c, s;
        int unsigned hd;
        int n;
        pose_t p;
        px = w.sx;
        py = w.sy;
        vx = w.vx;
        vy = w.vy;
        vt = w.vt;
        hd = {w.shd, 8'h00};
        n = steps_reg;
        if (n < 1) n = 1;
        if (n > MAX_STEPS) n = MAX_STEPS;
        for (int k = 0; k < n; k++) begin
            if (k > 0) begin
                vx = project_vel(vx, rate_reg[0], rate_reg[1], longint'(w.tx));
                vy = project_vel(vy, rate_reg[2], rate_reg[3], longint'(w.ty));
                vt = project_vel(vt, rate_reg[4], rate_reg[5], longint'(w.tt));
                heading_cos_sin(int'(hd >> 8), c, s);
                px = sat_pos(px + (((vx * c - vy * s) * dt_reg) >>> 30));
                py = sat_pos(py + (((vx * s + vy * c) * dt_reg) >>> 30));
                hd = (hd + int'((vt * dt_reg) >>> 16)) & 24'hFFFFFF;
            end
            p.x = px[31:0];
            p.y = py[31:0];
            p.hd = hd[23:8];
            p.idx = k[IDX_W-1:0];
            p.last = (k == n - 1);
            pose_q.insert(pose_q.size(), p);
        end
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // pose checker
    always @(posedge aclk) begin
        pose_t p;
        if (aresetn && m_valid && m_ready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected pose word, step %0d", $time, m_step_index);
                err_cnt++;
            end else begin
                p = pose_q.pop_front();
                check_field("pose_x", p.x, m_pose_x);
                check_field("pose_y", p.y, m_pose_y);
                check_field("pose_heading", p.hd, m_pose_heading);
                check_field("step_index", p.idx, m_step_index);
                check_field("last_pose", p.last, m_last_pose);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off when requested
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            m_ready <= 1'b0;
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 10);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else if (aresetn && ++quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
        case (idx)
            REG_TIME_STEP: dt_reg = val[15:0];
            REG_STEPS:     steps_reg = val[6:0];
            default:       rate_reg[idx] = longint'($signed(val));
        endcase
    endtask

    task automatic write_all(logic [23:0] ax, logic [23:0] dx, logic [23:0] ay,
                             logic [23:0] dy, logic [23:0] at, logic [23:0] dtn,
                             logic [23:0] dt, logic [23:0] steps);
        write_reg(REG_ACCEL_X, ax);
        write_reg(REG_DECEL_X, dx);
        write_reg(REG_ACCEL_Y, ay);
        write_reg(REG_DECEL_Y, dy);
        write_reg(REG_ACCEL_TURN, at);
        write_reg(REG_DECEL_TURN, dtn);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_STEPS, steps);
    endtask

    // send one start word; called at a falling edge, returns at a falling edge
    task automatic send_word(start_word_t w);
        if (!no_idle && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_start_x <= w.sx;
        s_start_y <= w.sy;
        s_start_heading <= w.shd;
        s_cur_vx <= w.vx;
        s_cur_vy <= w.vy;
        s_cur_vturn <= w.vt;
        s_tgt_vx <= w.tx;
        s_tgt_vy <= w.ty;
        s_tgt_vturn <= w.tt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_rollout(w);
        @(negedge aclk);
    endtask

    // drop valid and let the block drain before touching registers
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pose_q.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    function automatic logic [23:0] rand_vel();
        if ($urandom_range(0, 1)) return 24'($urandom());
        return 24'($signed($urandom_range(0, 524287)) - 262144);
    endfunction

    function automatic start_word_t rand_word();
        start_word_t w;
        w.sx = $urandom();
        w.sy = $urandom();
        if ($urandom_range(0, 1)) begin
            w.sx = $signed(w.sx) >>> 8;
            w.sy = $signed(w.sy) >>> 8;
        end
        w.shd = 16'($urandom());
        w.vx = rand_vel();
        w.vy = rand_vel();
        w.vt = rand_vel();
        w.tx = rand_vel();
        w.ty = rand_vel();
        w.tt = rand_vel();
        return w;
    endfunction

    // field extremes at the reset configuration
    task automatic test_field_extremes();
        start_word_t w;
        w = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'hFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
              24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
        send_word(w);
        w = '{32'sh80000000, 32'sh80000000, 16'h0000, 24'sh800000, 24'sh800000,
              24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000};
        send_word(w);
        w = '{32'sh7FFFFF00, 32'sh80000100, 16'h4000, 24'sh800000, 24'sh7FFFFF,
              24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF};
        send_word(w);
        w = '{32'sh0, 32'sh0, 16'h8000, 24'sh010000, 24'sh0, 24'sh001000,
              24'sh010000, 24'sh0, 24'sh001000};
        send_word(w);
        w = '{32'sh12345, -32'sh54321, 16'hC000, 24'sh0, 24'sh0, 24'sh0,
              24'sh020000, -24'sh020000, 24'sh400000};
        send_word(w);
        w = '{32'sh0, 32'sh0, 16'h2000, -24'sh010000, 24'sh008000, -24'sh100000,
              24'sh030000, -24'sh030000, 24'sh100000};
        send_word(w);
        wait_drained();
    endtask

    // rollout lengths at and beyond the limits, zero and full time step
    task automatic test_step_counts();
        write_reg(REG_STEPS, 24'd0);
        send_word(rand_word());
        wait_drained();
        write_reg(REG_STEPS, 24'd1);
        send_word(rand_word());
        wait_drained();
        write_reg(REG_STEPS, 24'd127);
        send_word(rand_word());
        wait_drained();
        write_reg(REG_STEPS, 24'd64);
        send_word(rand_word());
        wait_drained();
        write_reg(REG_STEPS, 24'd8);
        write_reg(REG_TIME_STEP, 24'd0);
        send_word(rand_word());
        send_word(rand_word());
        wait_drained();
        write_reg(REG_TIME_STEP, 24'd65535);
        send_word(rand_word());
        send_word(rand_word());
        wait_drained();
    endtask

    // rates of the wrong sign and at both register extremes
    task automatic test_reversed_rates();
        write_all(24'h800000, 24'h7FFFFF, 24'hFFF000, 24'h001000, 24'h800000,
                  24'h7FFFFF, 24'd30000, 24'd6);
        repeat (3) send_word(rand_word());
        wait_drained();
        write_all(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                  24'h800000, 24'd1, 24'd4);
        repeat (3) send_word(rand_word());
        wait_drained();
    endtask

    // random words over a series of random configurations
    task automatic test_random();
        for (int ph = 0; ph < 10; ph++) begin
            no_idle = (ph == 4);
            write_all($urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 600000)),
                      $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'(-$urandom_range(0, 600000)),
                      $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 600000)),
                      $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'(-$urandom_range(0, 600000)),
                      24'($urandom()), 24'($urandom()),
                      $urandom_range(0, 1) ? 24'($urandom_range(1, 65535))
                                           : 24'($urandom_range(1, 8000)),
                      24'($urandom_range(1, 6)));
            repeat (40) send_word(rand_word());
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    // long receiver hold-off while words keep arriving
    task automatic test_backpressure();
        write_all(24'd163840, -24'sd163840, 24'd163840, -24'sd163840, 24'd4194304,
                  -24'sd4194304, 24'd6554, 24'd8);
        hold_req = 1'b1;
        repeat (30) send_word(rand_word());
        wait_drained();
    endtask

    initial begin
        rate_reg = '{163840, -163840, 163840, -163840, 4194304, -4194304};
        dt_reg = 6554;
        steps_reg = 15;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_field_extremes();
        test_step_counts();
        test_reversed_rates();
        test_random();
        test_backpressure();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
